>>> hw/rtl/rswg_pkg.sv
// ----------------------------------------------------------------------------
// rswg_pkg
// Shared types and constants of the ramp and square waveform generator:
// register indexes and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rswg_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_ENABLE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TICKS  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_TICKS  = 2'd3;

  // Reset values of the registers, before truncation to the field widths.
  localparam logic [31:0] PEAK_LEVEL_RST = 32'h7FF;
  localparam logic [31:0] HOLD_TICKS_RST = 32'd1000;
  localparam logic [31:0] RAMP_TICKS_RST = 32'd500;

  // Controller to datapath.
  typedef struct packed {
    logic start;  // tick beat with the flag set: capture result, step state
    logic mul;    // form peak_level * count
    logic load;   // seed the divider from the product
    logic step;   // one quotient bit
    logic emit;   // hand the pending result to the output register
  } rswg_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;  // the pending tick is a ramp step that needs a division
    logic out_hold;  // output register is full and not being taken
  } rswg_sts_t;

endpackage : rswg_pkg

`default_nettype wire

>>> hw/rtl/rswg_ctrl.sv
// ----------------------------------------------------------------------------
// rswg_ctrl
// Sequencer of the waveform generator: takes tick beats, runs the multiply
// and the bit-serial divide of a ramp step, then hands the result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rswg_ctrl #(
  parameter int unsigned LEVEL_BITS = 11
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_tick_flag,
  output logic                    in_ready,
  input  rswg_pkg::rswg_sts_t     sts,
  output rswg_pkg::rswg_cmd_t     cmd
);
  import rswg_pkg::*;

  localparam int unsigned CW = $clog2(LEVEL_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] bit_cnt_r, bit_cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_tick_flag) begin
          cmd.start = 1'b1;
          state_nxt = sts.need_div ? S_MUL : S_EMIT;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load    = 1'b1;
        bit_cnt_nxt = CW'(LEVEL_BITS - 1);
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.step    = 1'b1;
        bit_cnt_nxt = bit_cnt_r - CW'(1);
        if (bit_cnt_r == '0) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // Wait here while the previous result is still unclaimed.
        if (!sts.out_hold) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

endmodule : rswg_ctrl

`default_nettype wire

>>> hw/rtl/rswg_dpath.sv
// ----------------------------------------------------------------------------
// rswg_dpath
// Datapath of the waveform generator: configuration registers, waveform
// state, the multiplier and restoring divider for ramp levels, and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rswg_dpath #(
  parameter int unsigned LEVEL_BITS = 11,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned CFG_BITS   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rswg_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]               cfg_wdata,
  input  rswg_pkg::rswg_cmd_t                    cmd,
  output rswg_pkg::rswg_sts_t                    sts,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [LEVEL_BITS-1:0]                  out_dac_code
);
  import rswg_pkg::*;

  localparam int unsigned L = LEVEL_BITS;
  localparam int unsigned C = COUNT_BITS;

  // Configuration.
  logic [L-1:0] peak_level_r;
  logic         ramp_enable_r;
  logic [C-1:0] hold_ticks_r;
  logic [C-1:0] ramp_ticks_r;

  // Waveform state.
  logic [L-1:0] level_r, level_nxt;
  logic [C-1:0] ramp_count_r, ramp_count_nxt;
  logic [C-1:0] hold_count_r, hold_count_nxt;
  logic         in_ramp_r, in_ramp_nxt;
  logic         rising_r, rising_nxt;

  // Pending result and divider.
  logic [L-1:0]   res_r;
  logic           need_div_r, need_div_nxt;
  logic [C-1:0]   op_r, op_nxt;
  logic [C-1:0]   len_r, len;
  logic [L+C-1:0] prod_r;
  logic [C-1:0]   rem_r;
  logic [L-1:0]   quo_r;
  logic [C:0]     trial;
  logic [C:0]     diff;
  logic           ge;

  // Output register.
  logic         out_valid_r, out_valid_nxt;
  logic [L-1:0] out_code_r;

  logic [C-1:0] cnt_dn;
  logic         hold_done;

  assign len       = (ramp_ticks_r == '0) ? C'(1) : ramp_ticks_r;
  assign cnt_dn    = ramp_count_r - C'(1);
  assign hold_done = (hold_count_r >= hold_ticks_r);

  // Next waveform state for a tick; applied only on a start command.
  always_comb begin
    level_nxt      = level_r;
    ramp_count_nxt = ramp_count_r;
    hold_count_nxt = hold_count_r;
    in_ramp_nxt    = in_ramp_r;
    rising_nxt     = rising_r;
    need_div_nxt   = 1'b0;
    op_nxt         = ramp_count_r;
    if (ramp_enable_r) begin
      if (in_ramp_r) begin
        if (rising_r) begin
          if (ramp_count_r >= len) begin
            in_ramp_nxt = 1'b0;
            rising_nxt  = 1'b0;
          end else begin
            need_div_nxt   = 1'b1;
            ramp_count_nxt = ramp_count_r + C'(1);
          end
        end else begin
          if (ramp_count_r == '0) begin
            rising_nxt = 1'b1;
          end else begin
            ramp_count_nxt = cnt_dn;
            op_nxt         = cnt_dn;
            // A count at or past the ramp length saturates to the peak.
            if (cnt_dn >= len) begin
              level_nxt = peak_level_r;
            end else begin
              need_div_nxt = 1'b1;
            end
          end
        end
      end else begin
        if (hold_done) begin
          in_ramp_nxt    = 1'b1;
          rising_nxt     = 1'b0;
          hold_count_nxt = '0;
        end else begin
          hold_count_nxt = hold_count_r + C'(1);
        end
      end
    end else begin
      if (hold_done) begin
        level_nxt      = (level_r == peak_level_r) ? '0 : peak_level_r;
        hold_count_nxt = '0;
      end else begin
        hold_count_nxt = hold_count_r + C'(1);
      end
    end
  end

  // Restoring division step: the quotient shifts in where the low
  // dividend bits shift out.
  assign trial = {rem_r, quo_r[L-1]};
  assign diff  = trial - {1'b0, len_r};
  assign ge    = (trial >= {1'b0, len_r});

  assign sts.need_div = need_div_nxt;
  assign sts.out_hold = out_valid_r && !out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dac_code = out_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_level_r  <= L'(PEAK_LEVEL_RST);
      ramp_enable_r <= 1'b1;
      hold_ticks_r  <= C'(HOLD_TICKS_RST);
      ramp_ticks_r  <= C'(RAMP_TICKS_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PEAK_LEVEL:  peak_level_r  <= cfg_wdata[L-1:0];
        REG_RAMP_ENABLE: ramp_enable_r <= cfg_wdata[0];
        REG_HOLD_TICKS:  hold_ticks_r  <= cfg_wdata[C-1:0];
        REG_RAMP_TICKS:  ramp_ticks_r  <= cfg_wdata[C-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r      <= '0;
      ramp_count_r <= '0;
      hold_count_r <= '0;
      in_ramp_r    <= 1'b1;
      rising_r     <= 1'b1;
      need_div_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.start) begin
        level_r      <= level_nxt;
        ramp_count_r <= ramp_count_nxt;
        hold_count_r <= hold_count_nxt;
        in_ramp_r    <= in_ramp_nxt;
        rising_r     <= rising_nxt;
        need_div_r   <= need_div_nxt;
      end else if (cmd.emit && need_div_r) begin
        level_r <= quo_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_r <= level_r;
      op_r  <= op_nxt;
      len_r <= len;
    end
    if (cmd.mul) begin
      prod_r <= (L+C)'(peak_level_r) * (L+C)'(op_r);
    end
    // The product is below len * 2^L, so its high part is below len.
    if (cmd.load) begin
      rem_r <= prod_r[L+C-1:L];
      quo_r <= prod_r[L-1:0];
    end else if (cmd.step) begin
      rem_r <= ge ? diff[C-1:0] : trial[C-1:0];
      quo_r <= {quo_r[L-2:0], ge};
    end
    if (cmd.emit) begin
      out_code_r <= res_r;
    end
  end

endmodule : rswg_dpath

`default_nettype wire

>>> hw/rtl/ramp_square_waveform_generator_top.sv
// ----------------------------------------------------------------------------
// ramp_square_waveform_generator_top
// Trapezoid ramp or square wave source producing one DAC code per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat is one DAC update tick. A beat with in_tick_flag low is
//   taken and dropped. A beat with the flag high produces one output beat
//   carrying the level held before the tick, and then advances the waveform.
//   The cfg channel is always ready; write registers only while the block
//   is idle (index 0 peak level, 1 ramp enable, 2 hold ticks, 3 ramp ticks).
// Sequencing:
//   A ramp step multiplies peak by the count, then divides by the ramp
//   length one quotient bit per cycle before in_ready returns. Any other
//   tick with the flag set goes straight to hand-off, and a tick with the
//   flag clear does not lower in_ready at all. The result reaches the
//   output register as in_ready returns.
// Reset and stalls:
//   Synchronous reset loads the register defaults and starts a ramp-up at
//   level zero. The output register holds one result; while it waits, the
//   next tick is still accepted and worked, and stalls only at hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ramp_square_waveform_generator_top #(
  parameter int unsigned LEVEL_BITS = 11,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_tick_flag,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [LEVEL_BITS-1:0]                  out_dac_code,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rswg_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [((LEVEL_BITS > COUNT_BITS) ? LEVEL_BITS : COUNT_BITS)-1:0] cfg_wdata
);
  import rswg_pkg::*;

  localparam int unsigned CFG_BITS = (LEVEL_BITS > COUNT_BITS) ? LEVEL_BITS : COUNT_BITS;

  rswg_cmd_t cmd;
  rswg_sts_t sts;

  assign cfg_ready = 1'b1;

  rswg_ctrl #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_tick_flag (in_tick_flag),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  rswg_dpath #(
    .LEVEL_BITS (LEVEL_BITS),
    .COUNT_BITS (COUNT_BITS),
    .CFG_BITS   (CFG_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_dac_code (out_dac_code)
  );

  // A tick with the flag set always takes the sequencer out of idle.
  a_tick_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_tick_flag) |=> !in_ready)
    else $error("sequencer stayed ready after a tick beat");

  // A tick without the flag leaves the block ready.
  a_idle_tick : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_tick_flag) |=> in_ready)
    else $error("ignored tick started work");

  // A fresh result is loaded only as the sequencer returns to idle.
  a_emit_idle : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded while the sequencer is busy");

  // The generator never emits more than one result per flagged tick.
  a_no_dup : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && in_ready) |=> !out_valid || !in_ready || $past(cmd.emit))
    else $error("result repeated without a new tick");

endmodule : ramp_square_waveform_generator_top

`default_nettype wire
